// File: rtl/uprd_pkg.sv
// Package for the peer-pair relay decider: item types, codes and constants.
// Used by all modules under rtl; depends on nothing.
package uprd_pkg;

	typedef struct packed {
		logic [11:0] packet_length;
		logic [31:0] header_magic;
		logic [63:0] token_chars_0;
		logic [63:0] token_chars_1;
		logic [63:0] token_chars_2;
		logic [63:0] token_chars_3;
		logic [7:0]  byte_thirty_six;
		logic [7:0]  byte_thirty_seven;
		logic [63:0] ready_number_a;
		logic [63:0] ready_number_b;
		logic [31:0] source_ip;
		logic [15:0] source_port;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
	} out_item_t;

	typedef struct packed {
		logic        active;
		logic [31:0] ip;
		logic [15:0] port;
	} ep_t;

	// Item class decided by the front end
	localparam logic [2:0] CLS_DROP   = 3'd0;
	localparam logic [2:0] CLS_HEALTH = 3'd1;
	localparam logic [2:0] CLS_V3     = 3'd2;
	localparam logic [2:0] CLS_LEGACY = 3'd3;
	localparam logic [2:0] CLS_RELAY  = 3'd4;

	// Classified item handed to the back end
	typedef struct packed {
		logic [2:0]  cls;
		logic        tok_ok;
		logic [15:0] declared;
		logic        slot;
		logic        slot_ok;
		logic [63:0] key_a;
		logic [63:0] key_b;
		logic [31:0] ip;
		logic [15:0] port;
	} cls_item_t;

	localparam logic [2:0] ACT_DROP       = 3'd0;
	localparam logic [2:0] ACT_HEALTH     = 3'd1;
	localparam logic [2:0] ACT_REGISTERED = 3'd2;
	localparam logic [2:0] ACT_WAITING    = 3'd3;
	localparam logic [2:0] ACT_FORWARD    = 3'd4;

	localparam logic [31:0] MAGIC_REG    = 32'h53463447;
	localparam logic [31:0] MAGIC_HEALTH = 32'h53463448;
	localparam int LEN_HEALTH = 4;
	localparam int LEN_LEGACY = 4 + 32;
	localparam int LEN_V2     = 4 + 32 + 2;
	localparam int LEN_V3     = 4 + 32 + 1 + 1 + 8 + 8;
	localparam logic [7:0] V3_VERSION = 8'd3;

	localparam int TOKEN_REGS = 2;
	localparam logic [0:0] REG_TOKEN_HIGH = 1'b0;
	localparam logic [0:0] REG_TOKEN_LOW  = 1'b1;

	// One ASCII hex character to a nibble, with a valid flag on top
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

// File: rtl/uprd_front.sv
// Front end: accepts items, classifies them and checks the room token.
// Depends on uprd_pkg. Two stages: hex decode, then token compare.
module uprd_front #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  uprd_pkg::in_item_t   in_item,
	input  logic [63:0]          tok_high,
	input  logic [63:0]          tok_low,
	output logic                 out_valid,
	input  logic                 out_ready,
	output uprd_pkg::cls_item_t  out_item
);

	logic                v_s1, v_s2;
	uprd_pkg::cls_item_t c_s1, c_s2;
	logic [127:0]        val_s1;
	logic                hex_s1;

	logic [11:0]         len_c;
	logic [255:0]        chars_c;
	logic [127:0]        val_c;
	logic                hex_c;
	logic [4:0]          dig_c;
	uprd_pkg::cls_item_t c_c;
	uprd_pkg::cls_item_t c_tok;
	logic                adv2, adv1;

	// Clamp the length to the receive limit
	always_comb begin
		if (32'(in_item.packet_length) > 32'(MAX_PACKET_BYTES)) begin
			len_c = 12'(MAX_PACKET_BYTES);
		end else begin
			len_c = in_item.packet_length;
		end
	end

	// Decode 32 hex characters, independent per character
	assign chars_c = {in_item.token_chars_0, in_item.token_chars_1,
		in_item.token_chars_2, in_item.token_chars_3};
	always_comb begin
		hex_c = 1'b1;
		val_c = '0;
		dig_c = '0;
		for (int i = 0; i < 32; i++) begin
			dig_c = uprd_pkg::hex_digit(chars_c[8*i +: 8]);
			hex_c = hex_c & dig_c[4];
			val_c[4*i +: 4] = dig_c[3:0];
		end
	end

	// Classify
	always_comb begin
		c_c = '0;
		c_c.ip = in_item.source_ip;
		c_c.port = in_item.source_port;
		c_c.key_a = in_item.ready_number_a;
		c_c.key_b = in_item.ready_number_b;
		c_c.slot = in_item.byte_thirty_seven[0];
		c_c.slot_ok = (in_item.byte_thirty_seven[7:1] == 7'd0);
		if (len_c == 12'd0) begin
			c_c.cls = uprd_pkg::CLS_DROP;
		end else if (len_c == 12'(uprd_pkg::LEN_HEALTH)
				&& in_item.header_magic == uprd_pkg::MAGIC_HEALTH) begin
			c_c.cls = uprd_pkg::CLS_HEALTH;
		end else if (in_item.header_magic == uprd_pkg::MAGIC_REG
				&& len_c == 12'(uprd_pkg::LEN_V3)
				&& in_item.byte_thirty_six == uprd_pkg::V3_VERSION) begin
			c_c.cls = uprd_pkg::CLS_V3;
		end else if (in_item.header_magic == uprd_pkg::MAGIC_REG
				&& (len_c == 12'(uprd_pkg::LEN_LEGACY) || len_c == 12'(uprd_pkg::LEN_V2))) begin
			c_c.cls = uprd_pkg::CLS_LEGACY;
			if (len_c == 12'(uprd_pkg::LEN_V2)) begin
				c_c.declared = {in_item.byte_thirty_six, in_item.byte_thirty_seven};
			end
		end else begin
			c_c.cls = uprd_pkg::CLS_RELAY;
		end
	end

	// Compare the decoded token with the configured value
	always_comb begin
		c_tok = c_s1;
		c_tok.tok_ok = hex_s1 && val_s1 == {tok_high, tok_low};
	end

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv2) v_s2 <= v_s1;
			if (adv1) v_s1 <= in_valid;
		end
	end

	// Hold payloads; compare the token in the second stage
	always_ff @(posedge clk) begin
		if (adv1) begin
			c_s1 <= c_c;
			val_s1 <= val_c;
			hex_s1 <= hex_c;
		end
		if (adv2) begin
			c_s2 <= c_tok;
		end
	end

	assign out_valid = v_s2;
	assign out_item = c_s2;

endmodule

// File: rtl/uprd_queue.sv
// Two-entry queue between front and back end.
// Depends on uprd_pkg for the carried item type.
module uprd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  uprd_pkg::cls_item_t  wdata,
	input  logic                 pop,
	output logic                 empty,
	output uprd_pkg::cls_item_t  rdata
);

	uprd_pkg::cls_item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rp_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (do_pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wdata;
	end

endmodule

// File: rtl/uprd_back.sv
// Back end: applies one classified item to the endpoint tables and decides.
// Depends on uprd_pkg. One item per cycle into an output register while results are taken.
module uprd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  uprd_pkg::cls_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output uprd_pkg::out_item_t  out_item
);

	uprd_pkg::ep_t leg_q [2];
	uprd_pkg::ep_t act_q [2];
	uprd_pkg::ep_t pen_q [2];
	logic [63:0]   act_a_q, act_b_q, pen_a_q, pen_b_q;
	logic          act_v_q, pen_v_q;
	logic          ov_q;
	uprd_pkg::out_item_t o_q;

	uprd_pkg::ep_t leg_n [2];
	uprd_pkg::ep_t act_n [2];
	uprd_pkg::ep_t pen_n [2];
	logic [63:0]   act_a_n, act_b_n, pen_a_n, pen_b_n;
	logic          act_v_n, pen_v_n;
	uprd_pkg::out_item_t o_n;
	uprd_pkg::ep_t fs [2];
	logic          take;
	logic [1:0]    hit_ep, hit_ip, hit_dp;
	logic          k_ok, k, rebind, src_ok, src;
	uprd_pkg::cls_item_t c;

	assign in_ready = !ov_q || out_ready;
	assign take = in_valid && in_ready;
	assign c = in_item;

	// Next state and result for one item
	always_comb begin
		leg_n = leg_q; act_n = act_q; pen_n = pen_q;
		act_a_n = act_a_q; act_b_n = act_b_q; act_v_n = act_v_q;
		pen_a_n = pen_a_q; pen_b_n = pen_b_q; pen_v_n = pen_v_q;
		o_n = '0;
		fs = act_v_q ? act_q : leg_q;
		k_ok = 1'b0; k = 1'b0; rebind = 1'b0; src_ok = 1'b0; src = 1'b0;
		hit_ep = '0; hit_ip = '0; hit_dp = '0;
		unique case (c.cls)
			uprd_pkg::CLS_HEALTH: begin
				o_n = '{uprd_pkg::ACT_HEALTH, c.ip, c.port};
			end
			uprd_pkg::CLS_V3: begin
				if (c.tok_ok && c.slot_ok) begin
					if (act_v_q && act_a_q == c.key_a && act_b_q == c.key_b) begin
						act_n[c.slot] = '{1'b1, c.ip, c.port};
						o_n.action = (act_n[0].active && act_n[1].active)
							? uprd_pkg::ACT_REGISTERED : uprd_pkg::ACT_WAITING;
					end else begin
						if (!(pen_v_q && pen_a_q == c.key_a && pen_b_q == c.key_b)) begin
							pen_n[0] = '0; pen_n[1] = '0;
							pen_a_n = c.key_a; pen_b_n = c.key_b; pen_v_n = 1'b1;
						end
						pen_n[c.slot] = '{1'b1, c.ip, c.port};
						o_n.action = uprd_pkg::ACT_WAITING;
						// Promote a complete pending generation
						if (pen_n[0].active && pen_n[1].active) begin
							act_n = pen_n; act_a_n = pen_a_n; act_b_n = pen_b_n;
							act_v_n = 1'b1;
							pen_n[0] = '0; pen_n[1] = '0;
							pen_a_n = '0; pen_b_n = '0; pen_v_n = 1'b0;
							o_n.action = uprd_pkg::ACT_REGISTERED;
						end
					end
					o_n.dest_ip = c.ip; o_n.dest_port = c.port;
				end
			end
			uprd_pkg::CLS_LEGACY: begin
				for (int i = 0; i < 2; i++) begin
					hit_ep[i] = leg_q[i].active && leg_q[i].ip == c.ip
						&& leg_q[i].port == c.port;
					hit_ip[i] = leg_q[i].active && leg_q[i].ip == c.ip;
					hit_dp[i] = leg_q[i].active && leg_q[i].port == c.declared;
				end
				if (hit_ep != 2'b00) begin
					k_ok = 1'b1; k = !hit_ep[0];
				end else if (!leg_q[0].active || !leg_q[1].active) begin
					k_ok = 1'b1; k = leg_q[0].active;
				end else if (hit_ip == 2'b01 || hit_ip == 2'b10) begin
					k_ok = 1'b1; k = hit_ip[1];
				end else if (c.declared != 16'd0 && (hit_dp == 2'b01 || hit_dp == 2'b10)) begin
					k_ok = 1'b1; k = hit_dp[1];
				end
				if (c.tok_ok && k_ok) begin
					rebind = leg_q[k].active
						&& !(leg_q[k].ip == c.ip && leg_q[k].port == c.port);
					leg_n[k] = '{1'b1, c.ip, c.port};
					if (rebind) leg_n[!k].active = 1'b0;
					o_n.action = (leg_n[0].active && leg_n[1].active)
						? uprd_pkg::ACT_REGISTERED : uprd_pkg::ACT_WAITING;
					o_n.dest_ip = c.ip; o_n.dest_port = c.port;
				end
			end
			uprd_pkg::CLS_RELAY: begin
				for (int i = 0; i < 2; i++) begin
					hit_ep[i] = fs[i].active && fs[i].ip == c.ip && fs[i].port == c.port;
					hit_ip[i] = fs[i].active && fs[i].ip == c.ip;
				end
				if (hit_ep != 2'b00) begin
					src_ok = 1'b1; src = !hit_ep[0];
				end else if (!act_v_q && (hit_ip == 2'b01 || hit_ip == 2'b10)) begin
					src_ok = 1'b1; src = hit_ip[1];
					leg_n[src].ip = c.ip; leg_n[src].port = c.port;
				end
				if (src_ok && fs[!src].active) begin
					o_n = '{uprd_pkg::ACT_FORWARD, fs[!src].ip, fs[!src].port};
				end
			end
			default: begin
				o_n = '0;
			end
		endcase
	end

	// Commit state and hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				leg_q[i] <= '0; act_q[i] <= '0; pen_q[i] <= '0;
			end
			act_a_q <= '0; act_b_q <= '0; act_v_q <= 1'b0;
			pen_a_q <= '0; pen_b_q <= '0; pen_v_q <= 1'b0;
		end else begin
			if (in_ready) ov_q <= take;
			if (take) begin
				leg_q <= leg_n; act_q <= act_n; pen_q <= pen_n;
				act_a_q <= act_a_n; act_b_q <= act_b_n; act_v_q <= act_v_n;
				pen_a_q <= pen_a_n; pen_b_q <= pen_b_n; pen_v_q <= pen_v_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) o_q <= o_n;
	end

	assign out_valid = ov_q;
	assign out_item = o_q;

endmodule

// File: rtl/udp_peer_pair_relay_decider.sv
// Top level of the peer-pair relay decider; joins front end, queue and back end.
// Depends on uprd_pkg, uprd_front, uprd_queue and uprd_back.
//
// Takes one datagram header per push and returns exactly one decision per item, in
// order, on a queue-style result port. An item passes a two-stage front end (hex
// decode of the room token and class, then token compare), a two-entry queue and a
// back end that updates the endpoint tables into an output register. The result is
// on the ports (empty low) once that register holds it, and one item can be
// accepted every cycle while results are popped. Token registers must be written
// over the cfg channel only while idle; the block itself does not enforce this.
module udp_peer_pair_relay_decider #(
	parameter int MAX_PACKET_BYTES = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  uprd_pkg::in_item_t   in_item,
	output logic                 empty,
	input  logic                 pop,
	output uprd_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [0:0]           cfg_index,
	input  logic [63:0]          cfg_data
);

	logic [63:0]         tok_high_q, tok_low_q;
	logic                f_valid, f_ready, q_full, q_empty, b_ready, b_valid;
	uprd_pkg::cls_item_t f_item, q_item;
	logic                in_rdy;

	assign cfg_ready = 1'b1;

	// Write token registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_high_q <= '0;
			tok_low_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				uprd_pkg::REG_TOKEN_HIGH: tok_high_q <= cfg_data;
				uprd_pkg::REG_TOKEN_LOW:  tok_low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign full = !in_rdy;

	uprd_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(push), .in_ready(in_rdy), .in_item(in_item),
		.tok_high(tok_high_q), .tok_low(tok_low_q),
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	assign f_ready = !q_full;

	uprd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(f_valid), .full(q_full), .wdata(f_item),
		.pop(b_ready), .empty(q_empty), .rdata(q_item)
	);

	uprd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(!q_empty), .in_ready(b_ready), .in_item(q_item),
		.out_valid(b_valid), .out_ready(pop), .out_item(out_item)
	);

	assign empty = !b_valid;

endmodule
